FILE: rtl/pyw_pkg.sv
package pyw_pkg;

  localparam int ADDR_BITS_DEFAULT = 20;
  localparam int OUT_ADDR_W        = 20;
  localparam int CFG_DATA_W        = 20;
  localparam int CFG_INDEX_W       = 3;
  localparam int DIM_W             = 10;
  localparam int TRAIL_W           = 14;

  localparam logic [DIM_W-1:0] WIDTH_RESET      = 10'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RESET     = 10'd240;
  localparam logic [19:0]      PLANE_SIZE_RESET = 20'd76800;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHROMA_422   = 3'd0,
    CFG_WIDTH        = 3'd1,
    CFG_HEIGHT       = 3'd2,
    CFG_LUMA_START   = 3'd3,
    CFG_CHROMA_START = 3'd4,
    CFG_PLANE_SIZE   = 3'd5,
    CFG_LINE_WRAP    = 3'd6
  } cfg_index_t;

  localparam logic CHROMA_PLANE_V = 1'b0;
  localparam logic CHROMA_PLANE_U = 1'b1;

endpackage

FILE: rtl/packed_yuv422_to_planar_writer.sv
// Converts packed 4:2:2 capture words (low byte luma, high byte V/U alternating by word)
// into byte writes for a planar frame buffer, 4:2:0 or 4:2:2 depending on CFG_CHROMA_422.
// The result of a word is registered into the output register when the word is transferred.
// A word is accepted when the output register is empty or its result is taken in the
// same cycle, so with out_ready held high the block sustains one word per cycle, and
// each cycle with out_ready low while the output register is full holds off the input.
// Assert in_frame_start with the first word of each frame; words after the frame's
// trailing discards are passed through as empty results until the next frame start.
// The user must write configuration registers only while no transfer is in progress; unenforced.
module packed_yuv422_to_planar_writer
  import pyw_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_frame_start,
  input  logic [15:0]            in_fifo_word,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_luma_write,
  output logic [OUT_ADDR_W-1:0]  out_luma_address,
  output logic [7:0]             out_luma_value,
  output logic                   out_chroma_write,
  output logic                   out_chroma_plane,
  output logic [OUT_ADDR_W-1:0]  out_chroma_address,
  output logic [7:0]             out_chroma_value,
  output logic                   out_frame_done
);

  localparam int EXT_W = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

  // Configuration registers.
  logic              cfg_422_r;
  logic [DIM_W-1:0]  cfg_width_r;
  logic [DIM_W-1:0]  cfg_height_r;
  logic [19:0]       cfg_luma_start_r;
  logic [19:0]       cfg_chroma_start_r;
  logic [19:0]       cfg_plane_size_r;
  logic [DIM_W-1:0]  cfg_line_wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_422_r          <= 1'b0;
      cfg_width_r        <= WIDTH_RESET;
      cfg_height_r       <= HEIGHT_RESET;
      cfg_luma_start_r   <= '0;
      cfg_chroma_start_r <= '0;
      cfg_plane_size_r   <= PLANE_SIZE_RESET;
      cfg_line_wrap_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CHROMA_422:   cfg_422_r          <= cfg_wdata[0];
        CFG_WIDTH:        cfg_width_r        <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT:       cfg_height_r       <= cfg_wdata[DIM_W-1:0];
        CFG_LUMA_START:   cfg_luma_start_r   <= cfg_wdata;
        CFG_CHROMA_START: cfg_chroma_start_r <= cfg_wdata;
        CFG_PLANE_SIZE:   cfg_plane_size_r   <= cfg_wdata;
        CFG_LINE_WRAP:    cfg_line_wrap_r    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame geometry.
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   rowlen;
  logic [TRAIL_W-1:0] trail_total;
  logic               empty_frame;

  assign rows        = {cfg_height_r[DIM_W-1:4], 4'b0000};
  assign rowlen      = {cfg_width_r[DIM_W-1:4], 4'b0000};
  assign trail_total = TRAIL_W'(cfg_height_r[3:0]) * TRAIL_W'(cfg_width_r);
  assign empty_frame = (rows == '0) || (rowlen == '0);

  // Frame state.
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [DIM_W-1:0]     word_r, word_nxt;
  logic [ADDR_BITS-1:0] luma_ptr_r, luma_ptr_nxt;
  logic [ADDR_BITS-1:0] u_ptr_r, u_ptr_nxt;
  logic [ADDR_BITS-1:0] v_ptr_r, v_ptr_nxt;
  logic [TRAIL_W-1:0]   trail_r, trail_nxt;
  logic                 trail_phase_r, trail_phase_nxt;

  // Start-of-frame values.
  logic [19:0]          plane_step;
  logic [ADDR_BITS-1:0] u_start;
  logic [ADDR_BITS-1:0] v_start;

  assign plane_step = cfg_422_r ? (cfg_plane_size_r >> 1) : (cfg_plane_size_r >> 2);
  assign u_start    = ADDR_BITS'({1'b0, cfg_plane_size_r} + {1'b0, cfg_chroma_start_r});
  assign v_start    = u_start + ADDR_BITS'(plane_step);

  // State seen by the current word, after an optional frame restart.
  logic [DIM_W-1:0]     cur_row;
  logic [DIM_W-1:0]     cur_word;
  logic [ADDR_BITS-1:0] cur_luma;
  logic [ADDR_BITS-1:0] cur_u;
  logic [ADDR_BITS-1:0] cur_v;
  logic [TRAIL_W-1:0]   cur_trail;
  logic                 cur_phase;

  always_comb begin
    if (in_frame_start) begin
      cur_row   = empty_frame ? rows : '0;
      cur_word  = '0;
      cur_luma  = ADDR_BITS'(cfg_luma_start_r);
      cur_u     = u_start;
      cur_v     = v_start;
      cur_trail = '0;
      cur_phase = empty_frame && (trail_total != '0);
    end else begin
      cur_row   = row_r;
      cur_word  = word_r;
      cur_luma  = luma_ptr_r;
      cur_u     = u_ptr_r;
      cur_v     = v_ptr_r;
      cur_trail = trail_r;
      cur_phase = trail_phase_r;
    end
  end

  // Result of the current word.
  logic                 res_luma_write;
  logic                 res_chroma_write;
  logic                 res_chroma_plane;
  logic [ADDR_BITS-1:0] res_chroma_ptr;
  logic                 res_done;
  logic [TRAIL_W-1:0]   trail_inc;
  logic [DIM_W-1:0]     word_inc;
  logic [DIM_W-1:0]     row_inc;
  logic [ADDR_BITS-1:0] half_wrap;

  assign trail_inc = cur_trail + 1'b1;
  assign word_inc  = cur_word + 1'b1;
  assign row_inc   = cur_row + 1'b1;
  assign half_wrap = ADDR_BITS'(cfg_line_wrap_r[DIM_W-1:1]);

  always_comb begin
    row_nxt          = cur_row;
    word_nxt         = cur_word;
    luma_ptr_nxt     = cur_luma;
    u_ptr_nxt        = cur_u;
    v_ptr_nxt        = cur_v;
    trail_nxt        = cur_trail;
    trail_phase_nxt  = cur_phase;
    res_luma_write   = 1'b0;
    res_chroma_write = 1'b0;
    res_chroma_plane = CHROMA_PLANE_V;
    res_chroma_ptr   = '0;
    res_done         = 1'b0;

    if (cur_phase) begin
      trail_nxt = trail_inc;
      if (trail_inc >= trail_total) begin
        trail_phase_nxt = 1'b0;
        res_done        = 1'b1;
      end
    end else if (cur_row < rows && rowlen != '0) begin
      res_luma_write = 1'b1;
      luma_ptr_nxt   = cur_luma + 1'b1;

      if (cfg_422_r || !cur_row[0]) begin
        res_chroma_write = 1'b1;
        if (cur_word[0]) begin
          res_chroma_plane = CHROMA_PLANE_U;
          res_chroma_ptr   = cur_u;
          u_ptr_nxt        = cur_u + 1'b1;
        end else begin
          res_chroma_plane = CHROMA_PLANE_V;
          res_chroma_ptr   = cur_v;
          v_ptr_nxt        = cur_v + 1'b1;
        end
      end

      word_nxt = word_inc;
      if (word_inc >= rowlen) begin
        // End of row: skip the line wrap, chroma only after even rows.
        word_nxt     = '0;
        luma_ptr_nxt = cur_luma + 1'b1 + ADDR_BITS'(cfg_line_wrap_r);
        if (!cur_row[0]) begin
          u_ptr_nxt = u_ptr_nxt + half_wrap;
          v_ptr_nxt = v_ptr_nxt + half_wrap;
        end
        row_nxt = row_inc;
        if (row_inc >= rows) begin
          trail_nxt = '0;
          if (trail_total != '0) begin
            trail_phase_nxt = 1'b1;
          end else begin
            res_done = 1'b1;
          end
        end
      end
    end
  end

  logic in_xfer;
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r         <= '0;
      word_r        <= '0;
      luma_ptr_r    <= '0;
      u_ptr_r       <= '0;
      v_ptr_r       <= '0;
      trail_r       <= '0;
      trail_phase_r <= 1'b0;
    end else if (in_xfer) begin
      row_r         <= row_nxt;
      word_r        <= word_nxt;
      luma_ptr_r    <= luma_ptr_nxt;
      u_ptr_r       <= u_ptr_nxt;
      v_ptr_r       <= v_ptr_nxt;
      trail_r       <= trail_nxt;
      trail_phase_r <= trail_phase_nxt;
    end
  end

  // Output register.
  logic [EXT_W-1:0] luma_ext;
  logic [EXT_W-1:0] chroma_ext;
  logic             out_valid_r;

  assign luma_ext   = EXT_W'(cur_luma);
  assign chroma_ext = EXT_W'(res_chroma_ptr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_luma_write     <= res_luma_write;
      out_luma_address   <= res_luma_write ? luma_ext[OUT_ADDR_W-1:0] : '0;
      out_luma_value     <= res_luma_write ? in_fifo_word[7:0] : 8'h00;
      out_chroma_write   <= res_chroma_write;
      out_chroma_plane   <= res_chroma_plane;
      out_chroma_address <= chroma_ext[OUT_ADDR_W-1:0];
      out_chroma_value   <= res_chroma_write ? in_fifo_word[15:8] : 8'h00;
      out_frame_done     <= res_done;
    end
  end

  assign out_valid = out_valid_r;

endmodule
